FILE: hdl/lbb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbb_pkg
// Types and fixed constants shared by the LED blink / breathe controller.
// ----------------------------------------------------------------------------
package lbb_pkg;

    // Event kinds carried in the slave tuser
    typedef enum logic [1:0] {
        KIND_PRESS = 2'd0,
        KIND_BLINK = 2'd1,
        KIND_HOLD  = 2'd2,
        KIND_PWM   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  released;
    } t_evt;

    localparam int unsigned BLINK_W   = 6;
    localparam int unsigned HOLD_W    = 8;
    localparam int unsigned RATE_W    = 3;
    localparam int unsigned SECOND_W  = 4;
    localparam int unsigned TRI_W     = 3;

    localparam logic [BLINK_W-1:0]  BLINK_MAX        = 6'd63;
    localparam logic [HOLD_W-1:0]   HOLD_MAX         = 8'd255;
    localparam logic [HOLD_W-1:0]   LONG_PRESS_RESET = 8'd64;
    localparam logic [RATE_W-1:0]   RATE_LAST        = 3'd4;
    localparam logic [SECOND_W-1:0] TRI_SECONDS      = 4'd10;
    localparam logic [SECOND_W-1:0] HALF_SECONDS     = 4'd5;

    // Blink ticks per LED toggle; codes past the last rate act as rate 0
    function automatic logic [BLINK_W-1:0] rate_limit(input logic [RATE_W-1:0] sel);
        logic [BLINK_W-1:0] lim;
        unique case (sel)
            3'd1:    lim = 6'd16;
            3'd2:    lim = 6'd8;
            3'd3:    lim = 6'd2;
            3'd4:    lim = 6'd1;
            default: lim = 6'd32;
        endcase
        return lim;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/lbb_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbb_in_stage
// Input register: captures one event transfer and holds it until the engine
// takes it.
// ----------------------------------------------------------------------------
module lbb_in_stage
    import lbb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_evt i_evt,
    input  wire logic i_advance,
    output logic      o_valid,
    output t_evt      o_evt
);

    logic r_valid;
    t_evt r_evt;

    // Free slot, or the held event leaves this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_evt <= i_evt;
        end
    end

    assign o_valid = r_valid;
    assign o_evt   = r_evt;

endmodule
`default_nettype wire

FILE: hdl/lbb_duty.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbb_duty
// Breathing duty from the triangle position. Each duty level has its own
// position threshold, fixed at elaboration; the duty is the count of
// thresholds reached.
// ----------------------------------------------------------------------------
module lbb_duty
    import lbb_pkg::*;
#(
    parameter int unsigned PWM_STEPS          = 5,
    parameter int unsigned PERIODS_PER_SECOND = 675
) (
    input  wire logic [$clog2(PERIODS_PER_SECOND+1)-1:0] i_period,
    input  wire logic [SECOND_W-1:0]                     i_second,
    output logic      [$clog2(PWM_STEPS+1)-1:0]          o_duty
);

    localparam int unsigned DUTY_W   = $clog2(PWM_STEPS + 1);
    localparam int unsigned POS_W    = $clog2(6 * PERIODS_PER_SECOND);
    localparam int unsigned DutyDen  = 5 * PERIODS_PER_SECOND;
    localparam int unsigned PctFull  = 100;

    logic [SECOND_W-1:0]  w_down;
    logic [TRI_W-1:0]     w_tri;
    logic [POS_W-1:0]     w_pos;
    logic [PWM_STEPS-1:0] w_reached;
    logic [DUTY_W-1:0]    w_count;

    // Rising for the first half of the ten seconds, falling after
    assign w_down = TRI_SECONDS - i_second;
    assign w_tri  = (i_second < HALF_SECONDS) ? i_second[TRI_W-1:0] : w_down[TRI_W-1:0];
    assign w_pos  = POS_W'(i_period) + POS_W'(w_tri) * POS_W'(PERIODS_PER_SECOND);

    for (genvar k = 0; k < PWM_STEPS; k++) begin : g_level
        // Smallest percent that gives duty k+1, then smallest position for it
        localparam int unsigned PctMin = (PctFull * (k + 1) + PWM_STEPS - 1) / PWM_STEPS;
        localparam int unsigned PosMin = (PctMin * DutyDen + PctFull - 1) / PctFull;
        assign w_reached[k] = (w_pos >= POS_W'(PosMin));
    end

    always_comb begin
        w_count = '0;
        for (int k = 0; k < PWM_STEPS; k++) begin
            w_count = w_count + DUTY_W'(w_reached[k]);
        end
    end

    assign o_duty = w_count;

endmodule
`default_nettype wire

FILE: hdl/lbb_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbb_engine
// Controller state, per-event update and result register with its output
// handshake.
// ----------------------------------------------------------------------------
module lbb_engine
    import lbb_pkg::*;
#(
    parameter int unsigned PWM_STEPS          = 5,
    parameter int unsigned PERIODS_PER_SECOND = 675
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic [HOLD_W-1:0] i_cfg_data,
    input  wire logic              i_valid,
    input  wire t_evt              i_evt,
    output logic                   o_advance,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_led,
    output logic                   o_breathing
);

    localparam int unsigned STEP_W = $clog2(PWM_STEPS);
    localparam int unsigned PER_W  = $clog2(PERIODS_PER_SECOND + 1);
    localparam int unsigned DUTY_W = $clog2(PWM_STEPS + 1);
    localparam logic [STEP_W:0] STEPS_C  = (STEP_W + 1)'(PWM_STEPS);
    localparam logic [PER_W:0]  PERIOD_C = (PER_W + 1)'(PERIODS_PER_SECOND);

    logic [HOLD_W-1:0]   r_long_press;
    logic                r_breathe, n_breathe;
    logic                r_blink_en, n_blink_en;
    logic                r_hold_en, n_hold_en;
    logic                r_pwm_en, n_pwm_en;
    logic [RATE_W-1:0]   r_rate, n_rate;
    logic [BLINK_W-1:0]  r_blink, n_blink;
    logic [HOLD_W-1:0]   r_hold, n_hold;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [PER_W-1:0]    r_period, n_period;
    logic [SECOND_W-1:0] r_second, n_second;
    logic [DUTY_W-1:0]   r_duty, n_duty;
    logic                r_stale, n_stale;
    logic                r_led, n_led;
    logic                r_out_valid;

    logic [BLINK_W-1:0]  w_blink_inc;
    logic [HOLD_W-1:0]   w_hold_inc;
    logic [STEP_W:0]     w_step_inc;
    logic                w_step_wrap;
    logic [PER_W:0]      w_period_inc;
    logic                w_period_wrap;
    logic [STEP_W-1:0]   w_pwm_step;
    logic [PER_W-1:0]    w_pwm_period;
    logic [SECOND_W-1:0] w_second_inc;
    logic [SECOND_W-1:0] w_pwm_second;
    logic [DUTY_W-1:0]   w_duty_calc;
    logic [DUTY_W-1:0]   w_pwm_duty;

    assign o_advance = i_valid && (!r_out_valid || i_out_ready);

    // Saturating counters
    assign w_blink_inc = (r_blink < BLINK_MAX) ? r_blink + 1'b1 : r_blink;
    assign w_hold_inc  = (r_hold < HOLD_MAX) ? r_hold + 1'b1 : r_hold;

    // PWM step / period / second chain for a breathing PWM tick
    assign w_step_inc    = {1'b0, r_step} + 1'b1;
    assign w_step_wrap   = (w_step_inc >= STEPS_C);
    assign w_pwm_step    = w_step_wrap ? '0 : w_step_inc[STEP_W-1:0];
    assign w_period_inc  = {1'b0, r_period} + 1'b1;
    assign w_period_wrap = w_step_wrap && (w_period_inc >= PERIOD_C);
    assign w_pwm_period  = !w_step_wrap ? r_period
                         : (w_period_wrap ? '0 : w_period_inc[PER_W-1:0]);
    assign w_second_inc  = w_period_wrap ? r_second + 1'b1 : r_second;
    assign w_pwm_second  = (w_second_inc >= TRI_SECONDS) ? '0 : w_second_inc;

    lbb_duty #(
        .PWM_STEPS          (PWM_STEPS),
        .PERIODS_PER_SECOND (PERIODS_PER_SECOND)
    ) u_duty (
        .i_period (w_pwm_period),
        .i_second (w_pwm_second),
        .o_duty   (w_duty_calc)
    );

    assign w_pwm_duty = (r_stale || w_step_wrap) ? w_duty_calc : r_duty;

    always_comb begin
        n_breathe  = r_breathe;
        n_blink_en = r_blink_en;
        n_hold_en  = r_hold_en;
        n_pwm_en   = r_pwm_en;
        n_rate     = r_rate;
        n_blink    = r_blink;
        n_hold     = r_hold;
        n_step     = r_step;
        n_period   = r_period;
        n_second   = r_second;
        n_duty     = r_duty;
        n_stale    = r_stale;
        n_led      = r_led;
        unique case (i_evt.kind)
            KIND_PRESS: begin
                n_hold     = '0;
                n_hold_en  = 1'b1;
                n_blink_en = 1'b1;
                if (r_breathe) begin
                    n_breathe = 1'b0;
                    n_rate    = '0;
                end else begin
                    n_rate = (r_rate < RATE_LAST) ? r_rate + 1'b1 : '0;
                end
            end
            KIND_BLINK: begin
                if (r_blink_en) begin
                    n_blink = w_blink_inc;
                    if (!r_breathe) begin
                        if (w_blink_inc >= rate_limit(r_rate)) begin
                            n_blink = '0;
                            n_led   = !r_led;
                        end
                    end else begin
                        n_blink_en = 1'b0;
                        n_rate     = '0;
                    end
                end
            end
            KIND_HOLD: begin
                if (r_hold_en) begin
                    n_hold = w_hold_inc;
                    if (i_evt.released) begin
                        n_hold_en = 1'b0;
                    end
                    if (w_hold_inc >= r_long_press && !r_breathe) begin
                        n_blink_en = 1'b0;
                        n_hold_en  = 1'b0;
                        n_breathe  = 1'b1;
                        n_step     = '0;
                        n_period   = '0;
                        n_second   = '0;
                        n_stale    = 1'b1;
                        n_pwm_en   = 1'b1;
                    end
                end
            end
            KIND_PWM: begin
                if (r_pwm_en) begin
                    if (!r_breathe) begin
                        n_pwm_en = 1'b0;
                    end else begin
                        n_step   = w_pwm_step;
                        n_period = w_pwm_period;
                        n_second = w_pwm_second;
                        n_duty   = w_pwm_duty;
                        n_stale  = 1'b0;
                        n_led    = (DUTY_W + 1)'(w_pwm_step) < (DUTY_W + 1)'(w_pwm_duty);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press <= LONG_PRESS_RESET;
        end else if (i_cfg_valid) begin
            r_long_press <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_breathe  <= 1'b0;
            r_blink_en <= 1'b1;
            r_hold_en  <= 1'b0;
            r_pwm_en   <= 1'b0;
            r_rate     <= '0;
            r_blink    <= '0;
            r_hold     <= '0;
            r_step     <= '0;
            r_period   <= '0;
            r_second   <= '0;
            r_duty     <= '0;
            r_stale    <= 1'b1;
            r_led      <= 1'b0;
        end else if (o_advance) begin
            r_breathe  <= n_breathe;
            r_blink_en <= n_blink_en;
            r_hold_en  <= n_hold_en;
            r_pwm_en   <= n_pwm_en;
            r_rate     <= n_rate;
            r_blink    <= n_blink;
            r_hold     <= n_hold;
            r_step     <= n_step;
            r_period   <= n_period;
            r_second   <= n_second;
            r_duty     <= n_duty;
            r_stale    <= n_stale;
            r_led      <= n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // State only moves when the result slot is free, so it doubles as the result
    assign o_out_valid = r_out_valid;
    assign o_led       = r_led;
    assign o_breathing = r_breathe;

endmodule
`default_nettype wire

FILE: hdl/led_blink_breathe_controller_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_blink_breathe_controller_core
// One-LED blink / breathe controller driven by an event stream.
// ----------------------------------------------------------------------------
// Each event transfer (press edge, blink tick, hold tick or PWM tick) yields
// exactly one result transfer carrying the LED level and the breathing flag
// after that event. Throughput is one event per clock while results are taken;
// each event passes the input register and then the state / result register,
// with the whole update (counters, blink rate compare and the breathing duty
// lookup) done by logic between them. s_axis_tready depends combinationally on
// m_axis_tready, so the block keeps accepting while a result waits and stalls
// only when both registers are full. There is no clearing pass after reset.
// The long press threshold may be written at any time the block is idle;
// the configuration channel is always ready.
// ----------------------------------------------------------------------------
module led_blink_breathe_controller_core
    import lbb_pkg::*;
#(
    parameter int unsigned PWM_STEPS          = 5,
    parameter int unsigned PERIODS_PER_SECOND = 675
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration write: long press threshold in hold ticks
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data,
    // Event stream
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [0] button_level (1 = released), [7:1] zero
    input  wire logic [1:0] s_axis_tuser,   // [1:0] kind
    // Result stream
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [0] led, [7:1] zero
    output logic [0:0]      m_axis_tuser    // [0] breathing
);

    t_evt w_s_evt;
    t_evt w_q_evt;
    logic w_q_valid;
    logic w_advance;
    logic w_led;
    logic w_breathing;

    assign o_cfg_ready = 1'b1;

    // Pack the incoming fields for the input register
    assign w_s_evt.kind     = t_kind'(s_axis_tuser);
    assign w_s_evt.released = s_axis_tdata[0];

    lbb_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_evt     (w_s_evt),
        .i_advance (w_advance),
        .o_valid   (w_q_valid),
        .o_evt     (w_q_evt)
    );

    // Apply the held event to the controller state and present the result
    lbb_engine #(
        .PWM_STEPS          (PWM_STEPS),
        .PERIODS_PER_SECOND (PERIODS_PER_SECOND)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (w_q_valid),
        .i_evt       (w_q_evt),
        .o_advance   (w_advance),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_led       (w_led),
        .o_breathing (w_breathing)
    );

    assign m_axis_tdata = {7'b0, w_led};
    assign m_axis_tuser = w_breathing;

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED blink / breathe controller core.
// ----------------------------------------------------------------------------
// Drive event transfers (press, blink, hold and PWM ticks) with random gaps
// and result back-pressure. An in-bench LED model predicts the LED level and
// the breathing flag of every result. A short opening table covers reset
// behavior, rate cycling, entering and leaving breathing mode and a zero
// long-press threshold. Random phases then run mostly press-and-hold
// sequences under several thresholds. A closing PWM run stays in breathing
// mode with sparse blink and hold noise.
// ----------------------------------------------------------------------------
module tb_top;
    import lbb_pkg::*;

    localparam int unsigned BREATH_STEPS    = 5;
    localparam int unsigned PERIODS_PER_SEC = 675;
    localparam int unsigned SWEEP_TICKS     = 200;
    localparam int unsigned RX_HOLD_CYCLES  = 300;
    localparam int unsigned RX_HOLD_AFTER   = 400;
    localparam int unsigned BLINK_DIVS [5]  = '{32, 16, 8, 2, 1};
    localparam logic [7:0]  PHASE_THRESH [8] =
        '{8'd255, 8'd3, 8'd1, 8'd12, 8'd0, 8'd6, 8'd2, 8'd40};
    localparam int unsigned PHASE_ITEMS [8] = '{200, 100, 100, 100, 100, 100, 100, 100};

    typedef struct packed {
        logic led;
        logic breathing;
    } t_led_state;

    // Opening table row: either a threshold write or one event transfer
    typedef struct {
        bit         is_cfg;
        logic [7:0] cfg_val;
        t_kind      kind;
        logic       released;
        bit         typed;
        t_led_state want;      // {led, breathing}
    } t_drive_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;      // [0] button_level, [7:1] zero
    logic [1:0] s_tuser;      // [1:0] kind
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;      // [0] led, [7:1] zero
    logic [0:0] m_tuser;      // [0] breathing

    // LED model state
    logic [7:0]          lp_thresh;
    logic                brth, blk_en, hld_en, pwm_en, duty_dirty, led_q;
    logic [RATE_W-1:0]   rate_sel;
    logic [BLINK_W-1:0]  blk_cnt;
    logic [HOLD_W-1:0]   hld_cnt;
    logic [2:0]          pwm_pos;
    logic [9:0]          period_cnt;
    logic [SECOND_W-1:0] sec_cnt;
    logic [2:0]          duty_lvl;

    t_led_state  led_expect_q [$];
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned events_sent  = 0;

    // Gap control: each side runs stretches of 48 transfers with or without gaps
    int unsigned quiet_odds   = 1;
    int unsigned tx_quiet_left = 0;
    bit          tx_quiet     = 0;

    t_drive_row opening_rows [27];

    led_blink_breathe_controller_core #(
        .PWM_STEPS          (BREATH_STEPS),
        .PERIODS_PER_SECOND (PERIODS_PER_SEC)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("led_blink_breathe_controller_core test failed");
        $finish;
    end

    // Advance the LED model by one event and return the result it predicts
    function automatic t_led_state led_after_event(input t_kind kind, input logic released);
        int unsigned tri_sec;
        int unsigned pct;
        int unsigned div_idx;
        case (kind)
            KIND_PRESS: begin
                hld_cnt = '0;
                hld_en  = 1'b1;
                if (brth) begin
                    brth     = 1'b0;
                    rate_sel = '0;
                end else begin
                    rate_sel = (rate_sel >= RATE_LAST) ? '0 : rate_sel + 3'd1;
                end
                blk_en = 1'b1;
            end
            KIND_BLINK: begin
                if (blk_en) begin
                    if (blk_cnt < BLINK_MAX) blk_cnt = blk_cnt + 6'd1;
                    if (!brth) begin
                        div_idx = (rate_sel > RATE_LAST) ? 0 : rate_sel;
                        if (blk_cnt >= BLINK_DIVS[div_idx]) begin
                            blk_cnt = '0;
                            led_q   = ~led_q;
                        end
                    end else begin
                        blk_en   = 1'b0;
                        rate_sel = '0;
                    end
                end
            end
            KIND_HOLD: begin
                if (hld_en) begin
                    if (hld_cnt < HOLD_MAX) hld_cnt = hld_cnt + 8'd1;
                    if (released) hld_en = 1'b0;
                    if (hld_cnt >= lp_thresh && !brth) begin
                        blk_en     = 1'b0;
                        hld_en     = 1'b0;
                        brth       = 1'b1;
                        pwm_pos    = '0;
                        period_cnt = '0;
                        sec_cnt    = '0;
                        duty_dirty = 1'b1;
                        pwm_en     = 1'b1;
                    end
                end
            end
            default: begin
                if (pwm_en) begin
                    if (!brth) begin
                        pwm_en = 1'b0;
                    end else begin
                        pwm_pos = pwm_pos + 3'd1;
                        if (pwm_pos >= BREATH_STEPS) begin
                            pwm_pos    = '0;
                            period_cnt = period_cnt + 10'd1;
                            duty_dirty = 1'b1;
                            if (period_cnt >= PERIODS_PER_SEC) begin
                                period_cnt = '0;
                                sec_cnt    = sec_cnt + 4'd1;
                            end
                        end
                        if (sec_cnt >= TRI_SECONDS) sec_cnt = '0;
                        // Duty follows a triangle: up for half the seconds, down after
                        if (duty_dirty) begin
                            tri_sec = (sec_cnt < HALF_SECONDS) ? sec_cnt : TRI_SECONDS - sec_cnt;
                            pct = ((period_cnt + PERIODS_PER_SEC * tri_sec) * 100)
                                / (PERIODS_PER_SEC * HALF_SECONDS);
                            pct = pct * BREATH_STEPS / 100;
                            duty_lvl   = 3'((pct > BREATH_STEPS) ? BREATH_STEPS : pct);
                            duty_dirty = 1'b0;
                        end
                        led_q = (pwm_pos < duty_lvl);
                    end
                end
            end
        endcase
        return '{led_q, brth};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Offer one event; log its prediction on the accepting edge
    task automatic push_event(input t_kind kind, input logic released,
                              input bit typed = 1'b0, input t_led_state want = '0);
        int unsigned gap;
        t_led_state  pred;
        if (tx_quiet_left == 0) begin
            tx_quiet_left = 48;
            tx_quiet      = ($urandom_range(0, 3) < quiet_odds);
        end
        tx_quiet_left--;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, released};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pred = led_after_event(kind, released);
        led_expect_q.push_back(typed ? want : pred);
        events_sent++;
        @(negedge i_clk);
    endtask

    // Write the long-press threshold once the block has drained
    task automatic write_long_press(input logic [7:0] value);
        s_tvalid <= 1'b0;
        while (led_expect_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        lp_thresh = value;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // One random sequence, mostly press-then-hold runs around the threshold
    task automatic play_sequence(input logic [7:0] thresh);
        int unsigned pick;
        int unsigned len;
        int unsigned rel_at;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            push_event(KIND_PRESS, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) < 7) len = thresh + $urandom_range(0, 3);
            else                          len = $urandom_range(0, thresh + 3);
            rel_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len) : len + 1;
            for (int i = 0; i < len; i++) push_event(KIND_HOLD, i == rel_at);
        end else if (pick < 65) begin
            repeat ($urandom_range(1, 6)) push_event(KIND_PRESS, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 70)) push_event(KIND_BLINK, 1'($urandom_range(0, 1)));
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 40)) push_event(KIND_PWM, 1'($urandom_range(0, 1)));
        end else begin
            repeat ($urandom_range(1, 4))
                push_event(t_kind'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Result side: random back-pressure plus one long hold-off to fill the block
    initial begin
        int unsigned gap;
        int unsigned quiet_left;
        bit          quiet;
        bit          long_done;
        quiet_left = 0;
        quiet      = 1'b0;
        long_done  = 1'b0;
        m_tready   = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!long_done && results_seen >= RX_HOLD_AFTER) begin
                long_done = 1'b1;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end
            if (quiet_left == 0) begin
                quiet_left = 48;
                quiet      = ($urandom_range(0, 3) < quiet_odds);
            end
            quiet_left--;
            gap = quiet ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Compare every result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_led_state want;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (led_expect_q.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing pending", results_seen));
            end else begin
                want = led_expect_q.pop_front();
                if (m_tdata[0] !== want.led)
                    report_mismatch($sformatf("result %0d led %b, want %b",
                                              results_seen, m_tdata[0], want.led));
                if (m_tuser[0] !== want.breathing)
                    report_mismatch($sformatf("result %0d breathing %b, want %b",
                                              results_seen, m_tuser[0], want.breathing));
                if (m_tdata[7:1] !== 7'd0)
                    report_mismatch($sformatf("result %0d tdata pad %h not zero",
                                              results_seen, m_tdata[7:1]));
            end
        end
    end

    initial begin
        i_rst_n   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 8'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tuser   = KIND_PRESS;

        lp_thresh  = LONG_PRESS_RESET;
        brth       = 1'b0;
        blk_en     = 1'b1;
        hld_en     = 1'b0;
        pwm_en     = 1'b0;
        rate_sel   = '0;
        blk_cnt    = '0;
        hld_cnt    = '0;
        pwm_pos    = '0;
        period_cnt = '0;
        sec_cnt    = '0;
        duty_lvl   = '0;
        duty_dirty = 1'b1;
        led_q      = 1'b0;

        // want is {led, breathing}; untyped rows fall back to the model
        opening_rows = '{
            // Reset threshold: PWM and hold ticks with their enables off are ignored
            '{1'b0, 8'd0, KIND_PWM,   1'b0, 1'b1, 2'b00},
            '{1'b0, 8'd0, KIND_HOLD,  1'b0, 1'b1, 2'b00},
            '{1'b0, 8'd0, KIND_BLINK, 1'b1, 1'b1, 2'b00},
            // Step through the rates to the fastest one and toggle twice
            '{1'b0, 8'd0, KIND_PRESS, 1'b0, 1'b1, 2'b00},
            '{1'b0, 8'd0, KIND_PRESS, 1'b1, 1'b1, 2'b00},
            '{1'b0, 8'd0, KIND_PRESS, 1'b0, 1'b1, 2'b00},
            '{1'b0, 8'd0, KIND_PRESS, 1'b1, 1'b1, 2'b00},
            '{1'b0, 8'd0, KIND_BLINK, 1'b0, 1'b1, 2'b10},
            '{1'b0, 8'd0, KIND_BLINK, 1'b1, 1'b1, 2'b00},
            // Rate wraps back to the slowest; release stops the hold count
            '{1'b0, 8'd0, KIND_PRESS, 1'b0, 1'b1, 2'b00},
            '{1'b0, 8'd0, KIND_HOLD,  1'b0, 1'b1, 2'b00},
            '{1'b0, 8'd0, KIND_HOLD,  1'b1, 1'b1, 2'b00},
            '{1'b0, 8'd0, KIND_HOLD,  1'b0, 1'b1, 2'b00},
            // Threshold one: a single hold tick enters breathing
            '{1'b1, 8'd1, KIND_PRESS, 1'b0, 1'b0, 2'b00},
            '{1'b0, 8'd0, KIND_PRESS, 1'b0, 1'b1, 2'b00},
            '{1'b0, 8'd0, KIND_HOLD,  1'b1, 1'b1, 2'b01},
            '{1'b0, 8'd0, KIND_PWM,   1'b0, 1'b0, 2'b00},
            '{1'b0, 8'd0, KIND_BLINK, 1'b0, 1'b1, 2'b01},
            '{1'b0, 8'd0, KIND_BLINK, 1'b1, 1'b1, 2'b01},
            '{1'b0, 8'd0, KIND_HOLD,  1'b0, 1'b1, 2'b01},
            // Press leaves breathing; the next PWM tick only clears its enable
            '{1'b0, 8'd0, KIND_PRESS, 1'b1, 1'b1, 2'b00},
            '{1'b0, 8'd0, KIND_PWM,   1'b1, 1'b1, 2'b00},
            '{1'b0, 8'd0, KIND_PWM,   1'b0, 1'b1, 2'b00},
            // Threshold zero: the first hold tick in blink mode enters breathing
            '{1'b1, 8'd0, KIND_PRESS, 1'b0, 1'b0, 2'b00},
            '{1'b0, 8'd0, KIND_PRESS, 1'b0, 1'b1, 2'b00},
            '{1'b0, 8'd0, KIND_HOLD,  1'b0, 1'b1, 2'b01},
            '{1'b0, 8'd0, KIND_PWM,   1'b1, 1'b0, 2'b00}
        };

        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (opening_rows[i]) begin
            if (opening_rows[i].is_cfg)
                write_long_press(opening_rows[i].cfg_val);
            else
                push_event(opening_rows[i].kind, opening_rows[i].released,
                           opening_rows[i].typed, opening_rows[i].want);
        end

        // Random phases, one threshold each
        foreach (PHASE_THRESH[p]) begin
            int unsigned start;
            write_long_press(PHASE_THRESH[p]);
            start = events_sent;
            while (events_sent - start < PHASE_ITEMS[p]) play_sequence(PHASE_THRESH[p]);
        end

        // Stay in breathing mode for a PWM run with sparse blink and hold noise
        quiet_odds = 3;
        write_long_press(8'd1);
        push_event(KIND_PRESS, 1'b0);
        push_event(KIND_HOLD, 1'b1);
        for (int i = 0; i < SWEEP_TICKS; i++) begin
            if ($urandom_range(0, 199) == 0)
                push_event($urandom_range(0, 1) ? KIND_BLINK : KIND_HOLD,
                           1'($urandom_range(0, 1)));
            push_event(KIND_PWM, 1'($urandom_range(0, 1)));
        end

        // Drain, then wait for any stray result before reporting
        s_tvalid <= 1'b0;
        while (led_expect_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("led_blink_breathe_controller_core test passed");
        else
            $display("led_blink_breathe_controller_core test failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/lbb_pkg.sv
hdl/lbb_in_stage.sv
hdl/lbb_duty.sv
hdl/lbb_engine.sv
hdl/led_blink_breathe_controller_core.sv
test/tb_top.sv
